// ===== rtl/core/mqd_pkg.sv =====
// Shared types, codes and the probability-state table of the MQ decoder.
`default_nettype none
package mqd_pkg;

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CTX  = 2'd1;
   localparam logic [1:0] ST_NO_DATA  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [6:0] NUM_STATES = 7'd47;

   typedef struct packed {
      logic [15:0] q;
      logic [5:0]  nmps;
      logic [5:0]  nlps;
      logic        flip;
   } prob_entry_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] wdata;
   } fifo_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic       rd_valid;
      logic [7:0] rd_data;
   } fifo_stat_type;

   typedef struct packed {
      logic       bit_out;
      logic [6:0] idx;
      logic       mps;
      logic [1:0] status;
   } result_type;

   function automatic prob_entry_type prob_rom(input logic [6:0] idx);
      prob_entry_type e;
      case (idx)
         7'd0:  e = '{16'h5601,  6'd1,  6'd1, 1'b1};
         7'd1:  e = '{16'h3401,  6'd2,  6'd6, 1'b0};
         7'd2:  e = '{16'h1801,  6'd3,  6'd9, 1'b0};
         7'd3:  e = '{16'h0AC1,  6'd4, 6'd12, 1'b0};
         7'd4:  e = '{16'h0521,  6'd5, 6'd29, 1'b0};
         7'd5:  e = '{16'h0221, 6'd38, 6'd33, 1'b0};
         7'd6:  e = '{16'h5601,  6'd7,  6'd6, 1'b1};
         7'd7:  e = '{16'h5401,  6'd8, 6'd14, 1'b0};
         7'd8:  e = '{16'h4801,  6'd9, 6'd14, 1'b0};
         7'd9:  e = '{16'h3801, 6'd10, 6'd14, 1'b0};
         7'd10: e = '{16'h3001, 6'd11, 6'd17, 1'b0};
         7'd11: e = '{16'h2401, 6'd12, 6'd18, 1'b0};
         7'd12: e = '{16'h1C01, 6'd13, 6'd20, 1'b0};
         7'd13: e = '{16'h1601, 6'd29, 6'd21, 1'b0};
         7'd14: e = '{16'h5601, 6'd15, 6'd14, 1'b1};
         7'd15: e = '{16'h5401, 6'd16, 6'd14, 1'b0};
         7'd16: e = '{16'h5101, 6'd17, 6'd15, 1'b0};
         7'd17: e = '{16'h4801, 6'd18, 6'd16, 1'b0};
         7'd18: e = '{16'h3801, 6'd19, 6'd17, 1'b0};
         7'd19: e = '{16'h3401, 6'd20, 6'd18, 1'b0};
         7'd20: e = '{16'h3001, 6'd21, 6'd19, 1'b0};
         7'd21: e = '{16'h2801, 6'd22, 6'd19, 1'b0};
         7'd22: e = '{16'h2401, 6'd23, 6'd20, 1'b0};
         7'd23: e = '{16'h2201, 6'd24, 6'd21, 1'b0};
         7'd24: e = '{16'h1C01, 6'd25, 6'd22, 1'b0};
         7'd25: e = '{16'h1801, 6'd26, 6'd23, 1'b0};
         7'd26: e = '{16'h1601, 6'd27, 6'd24, 1'b0};
         7'd27: e = '{16'h1401, 6'd28, 6'd25, 1'b0};
         7'd28: e = '{16'h1201, 6'd29, 6'd26, 1'b0};
         7'd29: e = '{16'h1101, 6'd30, 6'd27, 1'b0};
         7'd30: e = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
         7'd31: e = '{16'h09C1, 6'd32, 6'd29, 1'b0};
         7'd32: e = '{16'h08A1, 6'd33, 6'd30, 1'b0};
         7'd33: e = '{16'h0521, 6'd34, 6'd31, 1'b0};
         7'd34: e = '{16'h0441, 6'd35, 6'd32, 1'b0};
         7'd35: e = '{16'h02A1, 6'd36, 6'd33, 1'b0};
         7'd36: e = '{16'h0221, 6'd37, 6'd34, 1'b0};
         7'd37: e = '{16'h0141, 6'd38, 6'd35, 1'b0};
         7'd38: e = '{16'h0111, 6'd39, 6'd36, 1'b0};
         7'd39: e = '{16'h0085, 6'd40, 6'd37, 1'b0};
         7'd40: e = '{16'h0049, 6'd41, 6'd38, 1'b0};
         7'd41: e = '{16'h0025, 6'd42, 6'd39, 1'b0};
         7'd42: e = '{16'h0015, 6'd43, 6'd40, 1'b0};
         7'd43: e = '{16'h0009, 6'd44, 6'd41, 1'b0};
         7'd44: e = '{16'h0005, 6'd45, 6'd42, 1'b0};
         7'd45: e = '{16'h0001, 6'd45, 6'd43, 1'b0};
         7'd46: e = '{16'h5601, 6'd46, 6'd46, 1'b0};
         default: e = '{16'h0000, 6'd0, 6'd0, 1'b0};
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mq_arithmetic_decoder_unit.sv =====
// Top level of the MQ arithmetic decoder: request and response channels.
//
// req_tuser carries the command (push byte, start, decode one bit, clear) and
// req_tdata the byte and context. Every command gives one response: decoded
// bit, new context index and MPS in rsp_tdata, status in rsp_tuser.
// Push, clear and rejected commands answer in the cycle after the transfer and
// the next transfer may follow at once.
// Start answers from the done state after the load and byte states: one or two
// pops of the byte memory, each waiting for the registered read of the new head.
// Decode answers from the done state after the decode state and one shift state
// per renormalising shift (none, or one to seventeen); byte fetches overlap the
// shifts, and the shift loop sets the rate at which bits are decoded.
// One command is worked on at a time; the next is taken once the response
// register is free or being emptied in the same cycle.
// Reset empties the byte FIFO and clears the code, interval and counter
// registers. When rsp_tready is low the response holds in its register and
// req_tready stays low until it is taken.
// The byte producer must stay ahead: an empty FIFO during decoding is taken
// as the end of the coded data.
`default_nettype none
module mq_arithmetic_decoder_unit #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // data_byte[7:0], ctx_index[14:8], ctx_mps[15]
   input  wire  [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // decoded_bit[0], new_index[7:1], new_mps[8], zero[15:9]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import mqd_pkg::*;

   fifo_cmd_type  fcmd;
   fifo_stat_type fstat;
   result_type    res;
   logic          res_valid;
   logic          core_idle;
   logic          out_free;
   logic          accept;

   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, rsp_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = core_idle && out_free;
   assign accept     = req_tvalid && req_tready;

   mqd_byte_fifo #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .fcmd  (fcmd),
      .fstat (fstat)
   );

   mqd_decoder_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_tuser),
      .data_byte (req_tdata[7:0]),
      .ctx_index (req_tdata[14:8]),
      .ctx_mps   (req_tdata[15]),
      .out_free  (out_free),
      .idle      (core_idle),
      .res_valid (res_valid),
      .res       (res),
      .fcmd      (fcmd),
      .fstat     (fstat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.mps, rsp_ff.idx, rsp_ff.bit_out};
   assign rsp_tuser  = rsp_ff.status;

endmodule
`default_nettype wire

// ===== rtl/core/mqd_byte_fifo.sv =====
// Compressed-byte FIFO held in a synchronous memory with a registered head read.
`default_nettype none
module mqd_byte_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  mqd_pkg::fifo_cmd_type  fcmd,
   output mqd_pkg::fifo_stat_type fstat
);
   import mqd_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [7:0]       fifo_mem_ff [FIFO_DEPTH];
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff, rd_valid_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      rd_valid_in = !fcmd.pop && !(fcmd.push && (tail_ff == head_ff)) && !fcmd.clear;
      if (fcmd.clear) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else begin
         if (fcmd.push) begin
            tail_in = ptr_next(tail_ff);
         end
         if (fcmd.pop) begin
            head_in = ptr_next(head_ff);
         end
         if (fcmd.push && !fcmd.pop) begin
            fill_in = fill_ff + 1'b1;
         end else if (fcmd.pop && !fcmd.push) begin
            fill_in = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fcmd.push && !fcmd.clear) begin
         fifo_mem_ff[tail_ff] <= fcmd.wdata;
      end
      rd_data_ff <= fifo_mem_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign fstat.empty    = (fill_ff == '0);
   assign fstat.full     = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign fstat.rd_valid = rd_valid_ff;
   assign fstat.rd_data  = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/mqd_decoder_core.sv =====
// Command sequencer with the code, interval and bit-count registers of the MQ decoder.
`default_nettype none
module mqd_decoder_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire  [1:0]             cmd,
   input  wire  [7:0]             data_byte,
   input  wire  [6:0]             ctx_index,
   input  wire                    ctx_mps,
   input  wire                    out_free,
   output logic                   idle,
   output logic                   res_valid,
   output mqd_pkg::result_type    res,
   output mqd_pkg::fifo_cmd_type  fcmd,
   input  mqd_pkg::fifo_stat_type fstat
);
   import mqd_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_BYTE  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic [31:0]    c_ff, c_in;
   logic [15:0]    a_ff, a_in;
   logic [3:0]     ct_ff, ct_in;
   logic [7:0]     cur_ff, cur_in;
   logic           mark_ff, mark_in;
   logic [4:0]     guard_ff, guard_in;
   prob_entry_type ent_ff, ent_in;
   result_type     res_ff, res_in;

   prob_entry_type rom_e;
   result_type     res_now;
   logic           immediate;

   logic [31:0]    bi_c;
   logic [7:0]     bi_cur;
   logic           bi_mark;
   logic [3:0]     bi_ct;
   logic           bi_pop;
   logic           bi_need;

   logic [15:0]    a_sub;
   logic           lps_small;
   logic           take_lps;
   logic           renorm;
   logic           bi_go;
   logic [31:0]    c_pre;
   logic [3:0]     ct_pre;

   assign rom_e = prob_rom(ctx_index);

   always_comb begin
      res_now   = '{1'b0, ctx_index, ctx_mps, ST_OK};
      immediate = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            immediate = 1'b1;
            if (fstat.full) begin
               res_now.status = ST_FULL;
            end
         end
         CMD_START: begin
            if (fstat.empty) begin
               immediate      = 1'b1;
               res_now.status = ST_NO_DATA;
            end
         end
         CMD_DECODE: begin
            if (ctx_index >= NUM_STATES) begin
               immediate      = 1'b1;
               res_now.status = ST_BAD_CTX;
            end
         end
         default: begin
            immediate = 1'b1;
         end
      endcase
   end

   always_comb begin
      bi_need = !mark_ff && !fstat.empty;
      bi_c    = c_ff;
      bi_cur  = cur_ff;
      bi_mark = mark_ff;
      bi_ct   = 4'd8;
      bi_pop  = 1'b0;
      if (mark_ff) begin
         bi_ct = 4'd8;
      end else if (cur_ff == 8'hFF) begin
         if (fstat.empty || (fstat.rd_data > 8'h8F)) begin
            bi_mark = 1'b1;
         end else begin
            bi_pop = 1'b1;
            bi_cur = fstat.rd_data;
            bi_c   = c_ff + 32'h0000_FE00 - {15'd0, fstat.rd_data, 9'd0};
            bi_ct  = 4'd7;
         end
      end else begin
         if (fstat.empty) begin
            bi_cur  = 8'hFF;
            bi_mark = 1'b1;
         end else begin
            bi_pop = 1'b1;
            bi_cur = fstat.rd_data;
            bi_c   = c_ff + 32'h0000_FF00 - {16'd0, fstat.rd_data, 8'd0};
         end
      end
   end

   always_comb begin
      a_sub     = a_ff - ent_ff.q;
      lps_small = (a_sub < ent_ff.q);
      bi_go     = (ct_ff == 4'd0);
      c_pre     = bi_go ? bi_c : c_ff;
      ct_pre    = bi_go ? bi_ct : ct_ff;
      take_lps  = 1'b0;
      renorm    = 1'b1;

      state_in = state_ff;
      c_in     = c_ff;
      a_in     = a_ff;
      ct_in    = ct_ff;
      cur_in   = cur_ff;
      mark_in  = mark_ff;
      guard_in = guard_ff;
      ent_in   = ent_ff;
      res_in   = res_ff;
      fcmd     = '{1'b0, 1'b0, 1'b0, data_byte};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = res_now;
               ent_in = rom_e;
               case (cmd)
                  CMD_PUSH: begin
                     fcmd.push = !fstat.full;
                  end
                  CMD_START: begin
                     if (!fstat.empty) begin
                        state_in = S_LOAD;
                     end
                  end
                  CMD_DECODE: begin
                     if (ctx_index < NUM_STATES) begin
                        state_in = S_DEC;
                     end
                  end
                  default: begin
                     fcmd.clear = 1'b1;
                     c_in       = '0;
                     a_in       = '0;
                     ct_in      = '0;
                     cur_in     = '0;
                     mark_in    = 1'b0;
                  end
               endcase
            end
         end
         S_DEC: begin
            a_in = a_sub;
            if (c_ff[31:16] < a_sub) begin
               if (a_sub[15]) begin
                  renorm = 1'b0;
               end else begin
                  take_lps = lps_small;
               end
            end else begin
               c_in     = c_ff - {a_sub, 16'd0};
               take_lps = !lps_small;
               a_in     = ent_ff.q;
            end
            guard_in = '0;
            if (renorm) begin
               state_in = S_SHIFT;
               if (take_lps) begin
                  res_in.bit_out = ~res_ff.mps;
                  res_in.mps     = res_ff.mps ^ ent_ff.flip;
                  res_in.idx     = {1'b0, ent_ff.nlps};
               end else begin
                  res_in.bit_out = res_ff.mps;
                  res_in.idx     = {1'b0, ent_ff.nmps};
               end
            end else begin
               state_in       = S_DONE;
               res_in.bit_out = res_ff.mps;
            end
         end
         S_LOAD: begin
            if (fstat.rd_valid) begin
               fcmd.pop = 1'b1;
               cur_in   = fstat.rd_data;
               c_in     = {8'd0, ~fstat.rd_data, 16'd0};
               mark_in  = 1'b0;
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (!(bi_need && !fstat.rd_valid)) begin
               fcmd.pop = bi_pop;
               cur_in   = bi_cur;
               mark_in  = bi_mark;
               c_in     = {bi_c[24:0], 7'd0};
               ct_in    = bi_ct - 4'd7;
               a_in     = 16'h8000;
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            if (!(bi_go && bi_need && !fstat.rd_valid)) begin
               if (bi_go) begin
                  fcmd.pop = bi_pop;
                  cur_in   = bi_cur;
                  mark_in  = bi_mark;
               end
               a_in     = {a_ff[14:0], 1'b0};
               c_in     = {c_pre[30:0], 1'b0};
               ct_in    = ct_pre - 4'd1;
               guard_in = guard_ff + 5'd1;
               if (a_ff[14] || (guard_ff == 5'd16)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         c_ff     <= '0;
         a_ff     <= '0;
         ct_ff    <= '0;
         cur_ff   <= '0;
         mark_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         c_ff     <= c_in;
         a_ff     <= a_in;
         ct_ff    <= ct_in;
         cur_ff   <= cur_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      guard_ff <= guard_in;
      ent_ff   <= ent_in;
      res_ff   <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (idle && accept && immediate) || (state_ff == S_DONE);
   assign res       = idle ? res_now : res_ff;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the MQ arithmetic decoder unit: command streams against a predictor.
module tb;
   import mqd_pkg::*;

   localparam int FIFO_DEPTH = 16;
   localparam int CYCLE_LIMIT = 800000;
   localparam int ITEM_TARGET = 1025;
   localparam int N_CTX = 8;
   localparam logic [16:0][7:0] LEAD_BYTES = {
      8'h00, 8'hFF, 8'h12, 8'h34, 8'hFF, 8'h7F, 8'h80, 8'h55, 8'hAA,
      8'hFF, 8'h00, 8'hC3, 8'h3C, 8'hFF, 8'h91, 8'hEE, 8'hFF
   };

   typedef struct packed {
      logic [15:0] qe;
      logic [6:0]  up;
      logic [6:0]  down;
      logic        swap;
   } qe_row_type;

   class mq_ledger;
      logic [31:0] code_c;
      logic [15:0] area_a;
      logic [3:0]  ct;
      logic [7:0]  last_byte;
      logic        marker;
      logic [7:0]  bytes_q[$];
      result_type  owed[$];
      int          fails;

      function new();
         fails = 0;
         wipe();
      endfunction

      function void wipe();
         code_c = '0;
         area_a = '0;
         ct = '0;
         last_byte = '0;
         marker = 1'b0;
         bytes_q.delete();
      endfunction

      function qe_row_type qe_row(input logic [6:0] idx);
         qe_row_type r;
         case (idx)
            7'd0:  r = {16'h5601, 7'd1, 7'd1, 1'b1};
            7'd1:  r = {16'h3401, 7'd2, 7'd6, 1'b0};
            7'd2:  r = {16'h1801, 7'd3, 7'd9, 1'b0};
            7'd3:  r = {16'h0AC1, 7'd4, 7'd12, 1'b0};
            7'd4:  r = {16'h0521, 7'd5, 7'd29, 1'b0};
            7'd5:  r = {16'h0221, 7'd38, 7'd33, 1'b0};
            7'd6:  r = {16'h5601, 7'd7, 7'd6, 1'b1};
            7'd7:  r = {16'h5401, 7'd8, 7'd14, 1'b0};
            7'd8:  r = {16'h4801, 7'd9, 7'd14, 1'b0};
            7'd9:  r = {16'h3801, 7'd10, 7'd14, 1'b0};
            7'd10: r = {16'h3001, 7'd11, 7'd17, 1'b0};
            7'd11: r = {16'h2401, 7'd12, 7'd18, 1'b0};
            7'd12: r = {16'h1C01, 7'd13, 7'd20, 1'b0};
            7'd13: r = {16'h1601, 7'd29, 7'd21, 1'b0};
            7'd14: r = {16'h5601, 7'd15, 7'd14, 1'b1};
            7'd15: r = {16'h5401, 7'd16, 7'd14, 1'b0};
            7'd16: r = {16'h5101, 7'd17, 7'd15, 1'b0};
            7'd17: r = {16'h4801, 7'd18, 7'd16, 1'b0};
            7'd18: r = {16'h3801, 7'd19, 7'd17, 1'b0};
            7'd19: r = {16'h3401, 7'd20, 7'd18, 1'b0};
            7'd20: r = {16'h3001, 7'd21, 7'd19, 1'b0};
            7'd21: r = {16'h2801, 7'd22, 7'd19, 1'b0};
            7'd22: r = {16'h2401, 7'd23, 7'd20, 1'b0};
            7'd23: r = {16'h2201, 7'd24, 7'd21, 1'b0};
            7'd24: r = {16'h1C01, 7'd25, 7'd22, 1'b0};
            7'd25: r = {16'h1801, 7'd26, 7'd23, 1'b0};
            7'd26: r = {16'h1601, 7'd27, 7'd24, 1'b0};
            7'd27: r = {16'h1401, 7'd28, 7'd25, 1'b0};
            7'd28: r = {16'h1201, 7'd29, 7'd26, 1'b0};
            7'd29: r = {16'h1101, 7'd30, 7'd27, 1'b0};
            7'd30: r = {16'h0AC1, 7'd31, 7'd28, 1'b0};
            7'd31: r = {16'h09C1, 7'd32, 7'd29, 1'b0};
            7'd32: r = {16'h08A1, 7'd33, 7'd30, 1'b0};
            7'd33: r = {16'h0521, 7'd34, 7'd31, 1'b0};
            7'd34: r = {16'h0441, 7'd35, 7'd32, 1'b0};
            7'd35: r = {16'h02A1, 7'd36, 7'd33, 1'b0};
            7'd36: r = {16'h0221, 7'd37, 7'd34, 1'b0};
            7'd37: r = {16'h0141, 7'd38, 7'd35, 1'b0};
            7'd38: r = {16'h0111, 7'd39, 7'd36, 1'b0};
            7'd39: r = {16'h0085, 7'd40, 7'd37, 1'b0};
            7'd40: r = {16'h0049, 7'd41, 7'd38, 1'b0};
            7'd41: r = {16'h0025, 7'd42, 7'd39, 1'b0};
            7'd42: r = {16'h0015, 7'd43, 7'd40, 1'b0};
            7'd43: r = {16'h0009, 7'd44, 7'd41, 1'b0};
            7'd44: r = {16'h0005, 7'd45, 7'd42, 1'b0};
            7'd45: r = {16'h0001, 7'd45, 7'd43, 1'b0};
            default: r = {16'h5601, 7'd46, 7'd46, 1'b0};
         endcase
         return r;
      endfunction

      function void byte_in();
         if (marker) begin
            ct = 4'd8;
         end else if (last_byte == 8'hFF) begin
            if (bytes_q.size() == 0 || bytes_q[0] > 8'h8F) begin
               marker = 1'b1;
               ct = 4'd8;
            end else begin
               last_byte = bytes_q.pop_front();
               code_c = code_c + 32'h0000FE00 - {15'd0, last_byte, 9'd0};
               ct = 4'd7;
            end
         end else if (bytes_q.size() == 0) begin
            last_byte = 8'hFF;
            marker = 1'b1;
            ct = 4'd8;
         end else begin
            last_byte = bytes_q.pop_front();
            code_c = code_c + 32'h0000FF00 - {16'd0, last_byte, 8'd0};
            ct = 4'd8;
         end
      endfunction

      function void renorm();
         int guard;
         guard = 0;
         do begin
            if (ct == 4'd0)
               byte_in();
            area_a = area_a << 1;
            code_c = code_c << 1;
            ct = ct - 4'd1;
            guard++;
         end while (!area_a[15] && guard < 17);
      endfunction

      function result_type run_command(input logic [1:0] cmd, input logic [7:0] data,
                                       input logic [6:0] idx, input logic mps);
         result_type r;
         qe_row_type row;
         logic take_lps;
         logic shift;
         r.bit_out = 1'b0;
         r.idx = idx;
         r.mps = mps;
         r.status = ST_OK;
         case (cmd)
            CMD_PUSH: begin
               if (bytes_q.size() >= FIFO_DEPTH)
                  r.status = ST_FULL;
               else
                  bytes_q.push_back(data);
            end
            CMD_START: begin
               if (bytes_q.size() == 0) begin
                  r.status = ST_NO_DATA;
               end else begin
                  marker = 1'b0;
                  last_byte = bytes_q.pop_front();
                  code_c = {8'h00, ~last_byte, 16'h0000};
                  byte_in();
                  code_c = code_c << 7;
                  ct = ct - 4'd7;
                  area_a = 16'h8000;
               end
            end
            CMD_DECODE: begin
               if (idx >= NUM_STATES) begin
                  r.status = ST_BAD_CTX;
               end else begin
                  row = qe_row(idx);
                  shift = 1'b1;
                  area_a = area_a - row.qe;
                  if (code_c[31:16] < area_a) begin
                     if (!area_a[15]) begin
                        take_lps = area_a < row.qe;
                     end else begin
                        take_lps = 1'b0;
                        shift = 1'b0;
                     end
                  end else begin
                     code_c = code_c - {area_a, 16'h0000};
                     take_lps = !(area_a < row.qe);
                     area_a = row.qe;
                  end
                  if (take_lps) begin
                     r.bit_out = ~mps;
                     r.mps = mps ^ row.swap;
                     r.idx = row.down;
                  end else begin
                     r.bit_out = mps;
                     if (shift)
                        r.idx = row.up;
                  end
                  if (shift)
                     renorm();
               end
            end
            default: begin
               wipe();
            end
         endcase
         return r;
      endfunction

      function result_type take_request(input logic [1:0] cmd, input logic [7:0] data,
                                        input logic [6:0] idx, input logic mps);
         result_type r;
         r = run_command(cmd, data, idx, mps);
         owed.push_back(r);
         return r;
      endfunction

      function void note_fail(input string msg);
         fails++;
         if (fails <= 10)
            $display("mismatch: %s", msg);
      endfunction

      function void match_reply(input logic [15:0] data, input logic [1:0] user);
         result_type want;
         if (owed.size() == 0) begin
            note_fail($sformatf("reply with nothing owed: tdata %h tuser %0d", data, user));
            return;
         end
         want = owed.pop_front();
         if (data !== {7'd0, want.mps, want.idx, want.bit_out} || user !== want.status)
            note_fail($sformatf(
               "bit %0d/%0d index %0d/%0d mps %0d/%0d status %0d/%0d pad %h (exp/act)",
               want.bit_out, data[0], want.idx, data[7:1], want.mps, data[8],
               want.status, user, data[15:9]));
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function int fifo_level();
         return bytes_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_PUSH;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [15:0] rsp_tdata;
   wire  [1:0]  rsp_tuser;

   mq_ledger   sb = new();
   int         items_sent = 0;
   int         cycle_count = 0;
   int         stall_left = 0;
   bit         calm = 1'b0;
   logic [7:0] prev_byte = 8'h00;
   logic [6:0] ctx_idx [N_CTX];
   logic       ctx_mps [N_CTX];

   mq_arithmetic_decoder_unit #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.match_reply(rsp_tdata, rsp_tuser);
   end

   function int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready = 1'b1;
         if ($urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   function logic [7:0] next_byte();
      logic [7:0] b;
      if (prev_byte == 8'hFF)
         b = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(8'h90, 8'hFF))
                                         : 8'($urandom_range(0, 8'h8F));
      else
         b = ($urandom_range(0, 6) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      prev_byte = b;
      return b;
   endfunction

   function void seed_contexts();
      for (int k = 0; k < N_CTX; k++) begin
         ctx_idx[k] = 7'($urandom_range(0, 46));
         ctx_mps[k] = 1'($urandom_range(0, 1));
      end
   endfunction

   task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data,
                           input logic [6:0] idx, input logic mps, output result_type got);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {mps, idx, data};
      do @(posedge clock); while (!req_tready);
      got = sb.take_request(cmd, data, idx, mps);
      items_sent++;
   endtask

   task automatic push_byte();
      result_type r;
      send_cmd(CMD_PUSH, next_byte(), 7'($urandom_range(0, 127)),
               1'($urandom_range(0, 1)), r);
   endtask

   task automatic decode_one();
      result_type r;
      int k;
      k = $urandom_range(0, N_CTX - 1);
      if ($urandom_range(0, 29) == 0) begin
         send_cmd(CMD_DECODE, 8'($urandom_range(0, 255)), 7'($urandom_range(47, 127)),
                  1'($urandom_range(0, 1)), r);
      end else begin
         send_cmd(CMD_DECODE, 8'($urandom_range(0, 255)), ctx_idx[k], ctx_mps[k], r);
         if (r.status == ST_OK) begin
            ctx_idx[k] = r.idx;
            ctx_mps[k] = r.mps;
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      result_type r;
      int n;
      int m;
      bit starve;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // decode ahead of any start, start on an empty FIFO, out-of-range context
      send_cmd(CMD_DECODE, 8'h00, 7'd0, 1'b0, r);
      send_cmd(CMD_START, 8'hFF, 7'd127, 1'b1, r);
      send_cmd(CMD_DECODE, 8'hFF, 7'd127, 1'b1, r);
      // fill to the brim with stuffing and a marker, then one byte too many
      for (int i = 16; i >= 0; i--)
         send_cmd(CMD_PUSH, LEAD_BYTES[i], 7'd46, i[0], r);
      send_cmd(CMD_START, 8'h00, 7'd0, 1'b0, r);
      send_cmd(CMD_DECODE, 8'h00, 7'd46, 1'b1, r);
      send_cmd(CMD_DECODE, 8'h00, 7'd0, 1'b0, r);
      send_cmd(CMD_DECODE, 8'h00, 7'd5, 1'b1, r);
      send_cmd(CMD_CLEAR, 8'hFF, 7'd127, 1'b1, r);

      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 7) == 0)
            drain();
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 1) == 0)
               send_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                        1'($urandom_range(0, 1)), r);
            prev_byte = 8'h00;
            n = $urandom_range(2, 10);
            repeat (n) begin
               if (sb.fifo_level() < FIFO_DEPTH)
                  push_byte();
            end
            send_cmd(CMD_START, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)), r);
            seed_contexts();
            starve = ($urandom_range(0, 7) == 0);
            m = $urandom_range(4, 40);
            repeat (m) begin
               // keep the producer ahead unless this run is meant to underrun
               if (!starve)
                  while (sb.fifo_level() < 3) push_byte();
               decode_one();
            end
         end else begin
            m = $urandom_range(3, 12);
            repeat (m)
               send_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), r);
         end
      end

      calm = 1'b0;
      drain();
      repeat (40) @(posedge clock);
      if (sb.fails == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
